>>> src/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned DivW = 64;

  typedef enum logic [3:0] {
    OpAdd     = 4'd0,
    OpSub     = 4'd1,
    OpMul     = 4'd2,
    OpDiv     = 4'd3,
    OpMin     = 4'd4,
    OpMax     = 4'd5,
    OpInc     = 4'd6,
    OpDec     = 4'd7,
    OpCmp     = 4'd8,
    OpFromInt = 4'd9,
    OpToInt   = 4'd10
  } op_e;

  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
  } cmp_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
    logic        dbz;
    logic        is_div;
    logic        is_mul;
    logic        neg;
  } early_t;

endpackage

>>> src/fpa_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes: one quotient bit per stage.
module fpa_divider #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);
  import fpa_pkg::*;

  logic [NumW-1:0] num_q [NumW+1];
  logic [NumW-1:0] quo_q [NumW+1];
  logic [DenW:0]   rem_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];

  always_comb begin
    num_q[0] = num_i;
    quo_q[0] = '0;
    rem_q[0] = '0;
    den_q[0] = den_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW:0] sh_d;
    logic [DenW:0] rem_d;
    logic          bit_d;
    logic [NumW-1:0] nq_q;
    logic [NumW-1:0] qq_q;
    logic [DenW:0]   rq_q;
    logic [DenW-1:0] dq_q;
    always_comb begin
      sh_d  = {rem_q[s][DenW-1:0], num_q[s][NumW-1]};
      bit_d = (sh_d >= {1'b0, den_q[s]});
      rem_d = bit_d ? (sh_d - {1'b0, den_q[s]}) : sh_d;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nq_q <= '0;
        qq_q <= '0;
        rq_q <= '0;
        dq_q <= '0;
      end else if (adv_i) begin
        nq_q <= {num_q[s][NumW-2:0], 1'b0};
        qq_q <= {quo_q[s][NumW-2:0], bit_d};
        rq_q <= rem_d;
        dq_q <= den_q[s];
      end
    end
    always_comb begin
      num_q[s+1] = nq_q;
      quo_q[s+1] = qq_q;
      rem_q[s+1] = rq_q;
      den_q[s+1] = dq_q;
    end
  end

  assign quo_o = quo_q[NumW];
endmodule

>>> src/fpa_front.sv
`timescale 1ns / 1ps
// Combinational decode: simple ops finish here, mul/div operands are prepared.
module fpa_front #(
  parameter int unsigned FracBits = fpa_pkg::FracBitsDefault
) (
  input  logic [3:0]          opcode_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output fpa_pkg::early_t     early_o,
  output fpa_pkg::cmp_t       cmp_o,
  output logic [63:0]         div_num_o,
  output logic [32:0]         div_den_o
);
  import fpa_pkg::*;

  localparam logic signed [63:0] MaxPos = 64'sd2147483647;
  localparam logic signed [63:0] MinNeg = -64'sd2147483648;

  logic signed [33:0] sum_w;
  logic signed [63:0] fi_w;
  logic [32:0] ma_w, mb_w;
  logic sum_ovf;
  logic [31:0] sum_sat;

  function automatic logic [31:0] sat34(input logic signed [33:0] v, output logic o);
    if (v > 34'sd2147483647) begin
      o = 1'b1; sat34 = 32'h7fffffff;
    end else if (v < -34'sd2147483648) begin
      o = 1'b1; sat34 = 32'h80000000;
    end else begin
      o = 1'b0; sat34 = v[31:0];
    end
  endfunction

  always_comb begin
    cmp_o.less    = a_i < b_i;
    cmp_o.equal   = a_i == b_i;
    cmp_o.greater = a_i > b_i;
    ma_w = a_i[31] ? (33'd0 - {a_i[31], a_i}) : {1'b0, a_i};
    mb_w = b_i[31] ? (33'd0 - {b_i[31], b_i}) : {1'b0, b_i};
    // Divide twice the scaled numerator so the quotient carries a half bit.
    div_num_o = 64'(ma_w) << (FracBits + 1);
    div_den_o = mb_w;
    fi_w = 64'(a_i) <<< FracBits;
    early_o = '0;
    sum_w = '0;
    case (opcode_i)
      OpAdd: sum_w = 34'(a_i) + 34'(b_i);
      OpSub: sum_w = 34'(a_i) - 34'(b_i);
      OpInc: sum_w = 34'(a_i) + 34'sd1;
      OpDec: sum_w = 34'(a_i) - 34'sd1;
      default: sum_w = '0;
    endcase
    sum_sat = sat34(sum_w, sum_ovf);
    case (opcode_i)
      OpAdd, OpSub, OpInc, OpDec: begin
        early_o.value = sum_sat;
        early_o.ovf   = sum_ovf;
      end
      OpMul: begin
        early_o.is_mul = 1'b1;
        early_o.neg    = a_i[31] ^ b_i[31];
      end
      OpDiv: begin
        if (b_i == 32'sd0) begin
          early_o.dbz = 1'b1;
          early_o.value = a_i[31] ? 32'h80000000 :
                          ((a_i != 32'sd0) ? 32'h7fffffff : 32'h0);
        end else begin
          early_o.is_div = 1'b1;
          early_o.neg    = a_i[31] ^ b_i[31];
        end
      end
      OpMin: early_o.value = cmp_o.less ? a_i : b_i;
      OpMax: early_o.value = cmp_o.greater ? a_i : b_i;
      OpFromInt: begin
        if (fi_w > MaxPos) begin
          early_o.value = 32'h7fffffff; early_o.ovf = 1'b1;
        end else if (fi_w < MinNeg) begin
          early_o.value = 32'h80000000; early_o.ovf = 1'b1;
        end else begin
          early_o.value = fi_w[31:0];
        end
      end
      OpToInt: early_o.value = 32'(a_i >>> FracBits);
      default: early_o.value = '0;
    endcase
  end
endmodule

>>> src/fixed_point_alu.sv
`timescale 1ns / 1ps
// Pipelined signed fixed-point ALU (FRAC_BITS fraction bits).
// Input channel: in_valid_i/in_stall_o with opcode_i, operand_a_i, operand_b_i.
// Output channel: out_valid_o/out_stall_i with the result and flag fields.
// A transfer happens when valid is high and stall is low.
// Pipeline: the result passes 64 divider stages, the first one merged with
// decode, then the round/saturate register; the multiply path is padded to
// the same depth. Throughput: one operation per cycle while the pipe is not
// stalled; the divider is fully pipelined with one quotient bit per stage
// and sets the depth for every opcode.
// Reset clears all valid bits; the pipe starts empty.
// When the receiver stalls and the last stage holds a result, the whole pipe
// holds and in_stall_o is raised; bubbles inside the pipe stay.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         opcode_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic               less_flag_o,
  output logic               equal_flag_o,
  output logic               greater_flag_o,
  output logic               overflow_flag_o,
  output logic               divide_by_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned Depth = DivW;

  early_t      early_w;
  cmp_t        cmp_w;
  logic [63:0] num_w;
  logic [32:0] den_w;
  logic [63:0] quo_w;
  logic        adv;

  fpa_front #(.FracBits(FRAC_BITS)) u_front (
    .opcode_i (opcode_i),
    .a_i      (operand_a_i),
    .b_i      (operand_b_i),
    .early_o  (early_w),
    .cmp_o    (cmp_w),
    .div_num_o(num_w),
    .div_den_o(den_w)
  );

  // Valid bit for every stage; the pipe stalls as a whole.
  logic [Depth:0] vld_q;
  assign out_valid_o = vld_q[Depth];
  assign adv = !(vld_q[Depth] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-1:0], in_valid_i};
  end

  // Stage 1: register operands, decoded info.
  early_t      e_q [Depth];
  cmp_t        c_q [Depth];
  logic [63:0] prod_q;
  logic signed [31:0] a1_q, b1_q;
  logic [31:0] ma1_q, mb1_q;
  logic [63:0] pm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q[0] <= early_w;
      c_q[0] <= cmp_w;
      a1_q   <= operand_a_i;
      b1_q   <= operand_b_i;
      for (int i = 1; i < Depth; i++) begin
        e_q[i] <= e_q[i-1];
        c_q[i] <= c_q[i-1];
      end
      ma1_q  <= a1_q[31] ? (32'd0 - a1_q) : a1_q;
      mb1_q  <= b1_q[31] ? (32'd0 - b1_q) : b1_q;
      pm_q   <= 64'(ma1_q) * 64'(mb1_q);
      prod_q <= pm_q;
    end
  end

  fpa_divider #(.NumW(DivW), .DenW(33)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .num_i (num_w),
    .den_i (den_w),
    .quo_o (quo_w)
  );

  // Multiply product waits alongside the divider, already rounded.
  logic [63:0] pd_q [DivW-4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_q[0] <= (prod_q + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      for (int i = 1; i < DivW - 4; i++) pd_q[i] <= pd_q[i-1];
    end
  end

  // Final stage: round and saturate.
  // The divider yields q2 = floor(2n/d); (q2+1)>>1 rounds n/d half away from zero.
  early_t   ef;
  logic [63:0] mq, pmag;
  logic [64:0] q_r;
  logic [31:0] res_d;
  logic        ovf_d;
  logic signed [31:0] res_q;
  logic        ovf_q, dbz_q;
  cmp_t        cf_q;

  always_comb begin
    ef   = e_q[Depth-1];
    pmag = pd_q[DivW-5];
    mq   = '0;
    if (ef.is_mul) mq = pmag;
    else           mq = (quo_w + 64'd1) >> 1;
    q_r   = {1'b0, mq};
    res_d = ef.value;
    ovf_d = ef.ovf;
    if (ef.is_mul || ef.is_div) begin
      if (ef.neg) begin
        if (q_r > 65'd2147483648) begin
          res_d = 32'h80000000; ovf_d = 1'b1;
        end else res_d = 32'(65'd0 - q_r);
      end else begin
        if (q_r > 65'd2147483647) begin
          res_d = 32'h7fffffff; ovf_d = 1'b1;
        end else res_d = q_r[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
      dbz_q <= ef.dbz;
      cf_q  <= c_q[Depth-1];
    end
  end

  assign result_value_o   = res_q;
  assign overflow_flag_o  = ovf_q;
  assign divide_by_zero_o = dbz_q;
  assign less_flag_o      = cf_q.less;
  assign equal_flag_o     = cf_q.equal;
  assign greater_flag_o   = cf_q.greater;
endmodule
